@@ design/touch_key_repeat_quadrature_emulator_assert.svh @@
// ----------------------------------------------------------------------------
// Touch key repeat assertion macros
// Shared concurrent assertion forms used by the touch key repeat design.
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEY_REPEAT_QUADRATURE_EMULATOR_ASSERT_SVH
`define TOUCH_KEY_REPEAT_QUADRATURE_EMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKRQE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkrqe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TKRQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkrqe assertion failed");

`endif

@@ design/tkrqe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch key repeat package
// Types, constants and the phase table shared by the touch key repeat block.
// ----------------------------------------------------------------------------
package tkrqe_pkg;

    localparam int COORD_W = 12;
    localparam int TIME_W  = 32;
    localparam int CFG_IDX_W = 4;
    localparam int PHASE_W = 3;

    localparam logic [TIME_W-1:0] PHASE_HOLD_MS  = 32'd10;
    localparam logic [TIME_W-1:0] FRESH_GAP_MS   = PHASE_HOLD_MS * 32'd5;
    localparam logic [TIME_W-1:0] SLOW_REPEAT_MS = 32'd250;
    localparam logic [TIME_W-1:0] FAST_REPEAT_MS = 32'd100;
    localparam logic [3:0]        FAST_AFTER     = 4'd10;
    localparam logic [3:0]        REPEAT_MAX     = 4'd15;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_Y_LOW     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_Y_HIGH    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_LOW    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_X_HIGH   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_X_LOW  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_X_HIGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X_LOW   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X_HIGH  = 4'd7;

    localparam logic [PHASE_W-1:0] PH_FIRST   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SEL_END = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ENC_END = 3'd4;

    typedef enum logic [1:0] {
        KEY_IDLE  = 2'd0,
        KEY_LEFT  = 2'd1,
        KEY_SEL   = 2'd2,
        KEY_RIGHT = 2'd3
    } key_t;

    typedef struct packed {
        key_t kind;
        logic beep;
        logic skip;
    } cmd_t;

    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic btn_level;
        logic btn_driven;
        logic hold_phase;
        logic beep;
        logic skip_mode;
        logic last;
    } beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic beat_t phase_out(cmd_t c, logic [PHASE_W-1:0] idx);
        beat_t b;
        b.enc_a      = 1'b1;
        b.enc_b      = 1'b1;
        b.btn_level  = 1'b1;
        b.btn_driven = 1'b0;
        b.hold_phase = 1'b0;
        b.beep       = 1'b0;
        b.skip_mode  = c.skip;
        b.last       = 1'b1;
        case (c.kind)
            KEY_SEL:
            begin
                b.btn_driven = 1'b1;
                if (idx == PH_FIRST)
                begin
                    b.btn_level  = 1'b0;
                    b.hold_phase = 1'b1;
                    b.beep       = c.beep;
                    b.last       = 1'b0;
                end
            end
            KEY_LEFT, KEY_RIGHT:
            begin
                b.btn_driven = 1'b1;
                b.hold_phase = (idx != PH_ENC_END);
                b.beep       = c.beep && (idx == PH_FIRST);
                b.last       = (idx == PH_ENC_END);
                case (idx)
                    3'd1:
                    begin
                        b.enc_a = (c.kind == KEY_RIGHT);
                        b.enc_b = (c.kind == KEY_LEFT);
                    end
                    3'd2:
                    begin
                        b.enc_a = 1'b0;
                        b.enc_b = 1'b0;
                    end
                    3'd3:
                    begin
                        b.enc_a = (c.kind == KEY_LEFT);
                        b.enc_b = (c.kind == KEY_RIGHT);
                    end
                    default:
                    begin
                        b.enc_a = 1'b1;
                        b.enc_b = 1'b1;
                    end
                endcase
            end
            default:
            begin
                b.last = 1'b1;
            end
        endcase
        return b;
    endfunction

endpackage

@@ design/tkrqe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch key repeat front end
// Holds the key boxes, hit-tests each sample, runs the repeat decision and
// pushes one command per accepted sample into the queue.
// ----------------------------------------------------------------------------
module tkrqe_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkrqe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tkrqe_pkg::COORD_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                pen_down,
    input  logic [tkrqe_pkg::COORD_W-1:0]       touch_x,
    input  logic [tkrqe_pkg::COORD_W-1:0]       touch_y,
    input  logic [tkrqe_pkg::TIME_W-1:0]        now_ms,
    input  tkrqe_pkg::q_status_t                q_status,
    output logic                                push,
    output tkrqe_pkg::cmd_t                     push_cmd
);

    logic [tkrqe_pkg::COORD_W-1:0] y_low_reg, y_high_reg;
    logic [tkrqe_pkg::COORD_W-1:0] lx_low_reg, lx_high_reg;
    logic [tkrqe_pkg::COORD_W-1:0] sx_low_reg, sx_high_reg;
    logic [tkrqe_pkg::COORD_W-1:0] rx_low_reg, rx_high_reg;

    tkrqe_pkg::key_t               last_key_reg, last_key_next;
    logic [tkrqe_pkg::TIME_W-1:0]  last_touch_reg, last_touch_next;
    logic [tkrqe_pkg::TIME_W-1:0]  last_repeat_reg, last_repeat_next;
    logic [3:0]                    repeat_count_reg, repeat_count_next;
    logic                          skip_reg, skip_next;

    tkrqe_pkg::key_t               key_hit;
    logic                          y_in;
    logic [tkrqe_pkg::TIME_W-1:0]  gap;
    logic [tkrqe_pkg::TIME_W-1:0]  since;
    logic                          fire;
    logic                          beep;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign push      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_low_reg   <= '0;
            y_high_reg  <= '0;
            lx_low_reg  <= '0;
            lx_high_reg <= '0;
            sx_low_reg  <= '0;
            sx_high_reg <= '0;
            rx_low_reg  <= '0;
            rx_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tkrqe_pkg::REG_KEY_Y_LOW:     y_low_reg   <= cfg_data;
                tkrqe_pkg::REG_KEY_Y_HIGH:    y_high_reg  <= cfg_data;
                tkrqe_pkg::REG_LEFT_X_LOW:    lx_low_reg  <= cfg_data;
                tkrqe_pkg::REG_LEFT_X_HIGH:   lx_high_reg <= cfg_data;
                tkrqe_pkg::REG_SELECT_X_LOW:  sx_low_reg  <= cfg_data;
                tkrqe_pkg::REG_SELECT_X_HIGH: sx_high_reg <= cfg_data;
                tkrqe_pkg::REG_RIGHT_X_LOW:   rx_low_reg  <= cfg_data;
                tkrqe_pkg::REG_RIGHT_X_HIGH:  rx_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        y_in = (touch_y > y_low_reg) && (touch_y < y_high_reg);
        if (y_in && (touch_x > lx_low_reg) && (touch_x < lx_high_reg))
            key_hit = tkrqe_pkg::KEY_LEFT;
        else if (y_in && (touch_x > sx_low_reg) && (touch_x < sx_high_reg))
            key_hit = tkrqe_pkg::KEY_SEL;
        else if (y_in && (touch_x > rx_low_reg) && (touch_x < rx_high_reg))
            key_hit = tkrqe_pkg::KEY_RIGHT;
        else
            key_hit = tkrqe_pkg::KEY_IDLE;

        gap   = now_ms - last_touch_reg;
        since = now_ms - last_repeat_reg;

        last_key_next     = last_key_reg;
        last_touch_next   = last_touch_reg;
        last_repeat_next  = last_repeat_reg;
        repeat_count_next = repeat_count_reg;
        skip_next         = skip_reg;
        fire              = 1'b0;
        beep              = 1'b0;

        if (!pen_down)
        begin
            skip_next = 1'b0;
        end
        else if (key_hit != tkrqe_pkg::KEY_IDLE)
        begin
            skip_next       = 1'b1;
            last_touch_next = now_ms;
            if ((key_hit != last_key_reg) || (gap >= tkrqe_pkg::FRESH_GAP_MS))
            begin
                last_key_next     = key_hit;
                repeat_count_next = '0;
                last_repeat_next  = now_ms;
                fire              = 1'b1;
                beep              = 1'b1;
            end
            else if ((repeat_count_reg >= tkrqe_pkg::FAST_AFTER) &&
                     (since > tkrqe_pkg::FAST_REPEAT_MS))
            begin
                last_repeat_next = now_ms;
                fire             = 1'b1;
            end
            else if (since > tkrqe_pkg::SLOW_REPEAT_MS)
            begin
                last_repeat_next = now_ms;
                if (repeat_count_reg != tkrqe_pkg::REPEAT_MAX)
                    repeat_count_next = repeat_count_reg + 4'd1;
                fire = 1'b1;
            end
        end

        push_cmd.kind = fire ? key_hit : tkrqe_pkg::KEY_IDLE;
        push_cmd.beep = beep;
        push_cmd.skip = skip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg     <= tkrqe_pkg::KEY_IDLE;
            last_touch_reg   <= '0;
            last_repeat_reg  <= '0;
            repeat_count_reg <= '0;
            skip_reg         <= 1'b0;
        end
        else if (push)
        begin
            last_key_reg     <= last_key_next;
            last_touch_reg   <= last_touch_next;
            last_repeat_reg  <= last_repeat_next;
            repeat_count_reg <= repeat_count_next;
            skip_reg         <= skip_next;
        end
    end

endmodule

@@ design/tkrqe_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch key repeat command queue
// Small first-in first-out buffer of decided commands between the two ends.
// ----------------------------------------------------------------------------
`include "touch_key_repeat_quadrature_emulator_assert.svh"

module tkrqe_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tkrqe_pkg::cmd_t       push_cmd,
    input  logic                  pop,
    output tkrqe_pkg::cmd_t       head,
    output tkrqe_pkg::q_status_t  q_status
);

    tkrqe_pkg::cmd_t                  mem_reg [tkrqe_pkg::QDEPTH];
    logic [tkrqe_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tkrqe_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tkrqe_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign head           = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == tkrqe_pkg::QCNT_W'(tkrqe_pkg::QDEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `TKRQE_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !q_status.full)
    `TKRQE_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, !q_status.empty)
    `TKRQE_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ design/tkrqe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch key repeat back end
// Expands the queue head into its pin phases, one beat per cycle while the
// queue is not empty and out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module tkrqe_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tkrqe_pkg::cmd_t       head,
    input  tkrqe_pkg::q_status_t  q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tkrqe_pkg::beat_t      beat
);

    logic [tkrqe_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                          out_valid_reg, out_valid_next;
    tkrqe_pkg::beat_t              beat_reg;
    tkrqe_pkg::beat_t              beat_now;
    logic                          advance;
    logic                          emit;

    assign out_valid = out_valid_reg;
    assign beat      = beat_reg;

    always_comb
    begin
        advance        = !out_valid_reg || out_ready;
        emit           = advance && !q_status.empty;
        beat_now       = tkrqe_pkg::phase_out(head, phase_reg);
        pop            = emit && beat_now.last;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            phase_next     = beat_now.last ? tkrqe_pkg::PH_FIRST : phase_reg + 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            beat_reg <= beat_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tkrqe_pkg::PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/touch_key_repeat_quadrature_emulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch key repeat with quadrature encoder emulation
// Top level: front end, command queue and phase back end.
// ----------------------------------------------------------------------------
// A touch sample is accepted whenever the four-entry command queue has
// room, and each sample yields one, two or five result beats: a rest beat,
// a select pulse or five Gray-code encoder phases. The back end emits one
// beat per cycle from its output register while out_ready does not stall
// it. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module touch_key_repeat_quadrature_emulator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkrqe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tkrqe_pkg::COORD_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                pen_down,
    input  logic [tkrqe_pkg::COORD_W-1:0]       touch_x,
    input  logic [tkrqe_pkg::COORD_W-1:0]       touch_y,
    input  logic [tkrqe_pkg::TIME_W-1:0]        now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                enc_a,
    output logic                                enc_b,
    output logic                                btn_level,
    output logic                                btn_driven,
    output logic                                hold_phase,
    output logic                                beep,
    output logic                                skip_mode,
    output logic                                last
);

    logic                  push;
    tkrqe_pkg::cmd_t       push_cmd;
    logic                  pop;
    tkrqe_pkg::cmd_t       head;
    tkrqe_pkg::q_status_t  q_status;
    tkrqe_pkg::beat_t      beat;

    tkrqe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pen_down  (pen_down),
        .touch_x   (touch_x),
        .touch_y   (touch_y),
        .now_ms    (now_ms),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tkrqe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    tkrqe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .beat      (beat)
    );

    assign enc_a      = beat.enc_a;
    assign enc_b      = beat.enc_b;
    assign btn_level  = beat.btn_level;
    assign btn_driven = beat.btn_driven;
    assign hold_phase = beat.hold_phase;
    assign beep       = beat.beep;
    assign skip_mode  = beat.skip_mode;
    assign last       = beat.last;

endmodule
